>>> src/lcasr_pkg.sv
// Shared types, codes and constants for the load-cell converter serial reader.
// No dependencies; used by lcasr_core and load_cell_adc_serial_reader.
package lcasr_pkg;

	// Stream widths
	localparam int SAMPLE_W    = 24;

	// Input kind codes (tuser)
	localparam logic KIND_TICK    = 1'b0;
	localparam logic KIND_RESTART = 1'b1;

	// Configuration register indexes
	localparam logic [1:0] CFG_GAIN    = 2'd0;
	localparam logic [1:0] CFG_TIMEOUT = 2'd1;
	localparam logic [1:0] CFG_HALF    = 2'd2;

	// Gain codes
	localparam logic [1:0] GAIN_128 = 2'd0;
	localparam logic [1:0] GAIN_64  = 2'd1;
	localparam logic [1:0] GAIN_32  = 2'd2;

	// Status codes
	localparam logic [1:0] STATUS_START = 2'd0;
	localparam logic [1:0] STATUS_RUN   = 2'd1;
	localparam logic [1:0] STATUS_SAT   = 2'd2;
	localparam logic [1:0] STATUS_FAULT = 2'd3;

	// Register reset values
	localparam logic [1:0]  GAIN_RST    = GAIN_128;
	localparam logic [23:0] TIMEOUT_RST = 24'd300000;
	localparam logic [5:0]  HALF_RST    = 6'd1;

	// Conversion constants
	localparam logic [4:0]  DATA_BITS = 5'd24;
	localparam logic [23:0] COUNT_MAX = 24'hFFFFFF;
	localparam logic [23:0] RAIL_POS  = 24'h7FFFFF;
	localparam logic [23:0] RAIL_NEG  = 24'h800000;

	typedef struct packed {
		logic [1:0]  gain_select;
		logic [23:0] timeout_ticks;
		logic [5:0]  half_period_ticks;
	} cfg_t;

	typedef struct packed {
		logic                       sck;
		logic                       sample_valid;
		logic signed [SAMPLE_W-1:0] sample;
		logic [1:0]                 status;
	} result_t;

	// Extra clock pulses after the data bits select the next gain/channel
	function automatic logic [1:0] extra_pulses(input logic [1:0] gain);
		logic [1:0] n;
		unique case (gain)
			GAIN_64: n = 2'd3;
			GAIN_32: n = 2'd2;
			default: n = 2'd1;
		endcase
		return n;
	endfunction

endpackage

>>> src/lcasr_core.sv
// Serial-clock sequencer and converter state for the load-cell reader.
// Computes one tick result combinationally; state advances on step_en.
// Depends on lcasr_pkg.
module lcasr_core #(
	parameter int POWERDOWN_TICKS = 70
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step_en,
	input  logic              kind,
	input  logic              dout_level,
	input  lcasr_pkg::cfg_t   cfg,
	output lcasr_pkg::result_t res
);

	localparam int PD_W = $clog2(POWERDOWN_TICKS + 1);
	localparam logic [PD_W-1:0] PD_LAST = PD_W'(POWERDOWN_TICKS);

	// Sequencer modes
	localparam logic [2:0] M_PDOWN  = 3'd0;
	localparam logic [2:0] M_WAIT   = 3'd1;
	localparam logic [2:0] M_BIT_HI = 3'd2;
	localparam logic [2:0] M_BIT_LO = 3'd3;
	localparam logic [2:0] M_EXT_HI = 3'd4;
	localparam logic [2:0] M_EXT_LO = 3'd5;
	localparam logic [2:0] M_FAULT  = 3'd6;

	logic [2:0]      mode_q, mode_d;
	logic [23:0]     shift_q, shift_d;
	logic [4:0]      bit_q, bit_d;
	logic [5:0]      phase_q, phase_d;
	logic [1:0]      extra_q, extra_d;
	logic [23:0]     tss_q, tss_d;
	logic [PD_W-1:0] pd_q, pd_d;
	logic            sat_q, sat_d;

	logic [5:0]      hp_eff;
	logic            phase_done;
	logic [5:0]      phase_adv;
	logic [23:0]     tss_inc;
	logic [PD_W-1:0] pd_inc;
	logic [1:0]      extra_dec;
	logic            sck;
	logic            valid;
	logic [23:0]     sample;
	logic [1:0]      status;

	// Phase timer: zero half period behaves as one
	assign hp_eff     = (cfg.half_period_ticks == 6'd0) ? 6'd1 : cfg.half_period_ticks;
	assign phase_done = ({1'b0, phase_q} + 7'd1) >= {1'b0, hp_eff};
	assign phase_adv  = phase_done ? 6'd0 : phase_q + 6'd1;

	// Saturating count of ticks since last result
	assign tss_inc = (mode_q >= M_WAIT && mode_q <= M_EXT_LO && tss_q != lcasr_pkg::COUNT_MAX)
		? tss_q + 24'd1 : tss_q;
	assign pd_inc    = pd_q + PD_W'(1);
	assign extra_dec = extra_q - 2'd1;

	// Next state and tick result
	always_comb begin
		mode_d  = mode_q;
		shift_d = shift_q;
		bit_d   = bit_q;
		phase_d = phase_q;
		extra_d = extra_q;
		tss_d   = tss_inc;
		pd_d    = pd_q;
		sat_d   = sat_q;
		sck     = 1'b0;
		valid   = 1'b0;
		sample  = 24'd0;
		if (kind == lcasr_pkg::KIND_RESTART) begin
			mode_d  = M_PDOWN;
			shift_d = 24'd0;
			bit_d   = 5'd0;
			phase_d = 6'd0;
			extra_d = 2'd0;
			tss_d   = 24'd0;
			pd_d    = '0;
			sat_d   = 1'b0;
			sck     = 1'b1;
		end else begin
			unique case (mode_q)
				M_PDOWN: begin
					sck  = 1'b1;
					pd_d = pd_inc;
					if (pd_inc >= PD_LAST) begin
						pd_d   = '0;
						tss_d  = 24'd0;
						mode_d = M_WAIT;
					end
				end
				M_WAIT: begin
					if (!dout_level) begin
						shift_d = 24'd0;
						bit_d   = 5'd0;
						phase_d = 6'd0;
						mode_d  = M_BIT_HI;
					end else if (tss_inc > cfg.timeout_ticks) begin
						mode_d = M_FAULT;
					end
				end
				M_BIT_HI: begin
					sck     = 1'b1;
					phase_d = phase_adv;
					if (phase_done) begin
						shift_d = {shift_q[22:0], dout_level};
						bit_d   = bit_q + 5'd1;
						mode_d  = M_BIT_LO;
					end
				end
				M_BIT_LO: begin
					phase_d = phase_adv;
					if (phase_done) begin
						if (bit_q >= lcasr_pkg::DATA_BITS) begin
							extra_d = lcasr_pkg::extra_pulses(cfg.gain_select);
							mode_d  = M_EXT_HI;
						end else begin
							mode_d = M_BIT_HI;
						end
					end
				end
				M_EXT_HI: begin
					sck     = 1'b1;
					phase_d = phase_adv;
					if (phase_done) mode_d = M_EXT_LO;
				end
				M_EXT_LO: begin
					phase_d = phase_adv;
					if (phase_done) begin
						extra_d = extra_dec;
						if (extra_dec == 2'd0) begin
							sat_d  = (shift_q == lcasr_pkg::RAIL_POS) ||
								(shift_q == lcasr_pkg::RAIL_NEG);
							valid  = 1'b1;
							sample = shift_q;
							tss_d  = 24'd0;
							bit_d  = 5'd0;
							mode_d = M_WAIT;
						end else begin
							mode_d = M_EXT_HI;
						end
					end
				end
				default: begin
					mode_d = M_FAULT;
				end
			endcase
		end
	end

	// Status follows the updated mode and warning flag
	always_comb begin
		priority if (mode_d == M_PDOWN) status = lcasr_pkg::STATUS_START;
		else if (mode_d == M_FAULT)     status = lcasr_pkg::STATUS_FAULT;
		else if (sat_d)                 status = lcasr_pkg::STATUS_SAT;
		else                            status = lcasr_pkg::STATUS_RUN;
	end

	assign res.sck          = sck;
	assign res.sample_valid = valid;
	assign res.sample       = sample;
	assign res.status       = status;

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_PDOWN;
			shift_q <= 24'd0;
			bit_q   <= 5'd0;
			phase_q <= 6'd0;
			extra_q <= 2'd0;
			tss_q   <= 24'd0;
			pd_q    <= '0;
			sat_q   <= 1'b0;
		end else if (step_en) begin
			mode_q  <= mode_d;
			shift_q <= shift_d;
			bit_q   <= bit_d;
			phase_q <= phase_d;
			extra_q <= extra_d;
			tss_q   <= tss_d;
			pd_q    <= pd_d;
			sat_q   <= sat_d;
		end
	end

endmodule

>>> src/load_cell_adc_serial_reader.sv
// Load-cell converter serial reader, top level.
// A tick's result goes through the input register and the result register to the master side.
// One tick per cycle without master stalls; input and result registers stall together.
// The converter state advances once per tick in lcasr_core.
// Reset (arst_n low) clears both stages, the converter state (power-down start) and
// the configuration registers to gain 128, timeout 300000, half period 1.
module load_cell_adc_serial_reader #(
	parameter int POWERDOWN_TICKS = 70
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [0] dout_level, [7:1] zero
	input  logic        s_axis_tuser,  // [0] kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [0] sck, [1] sample_valid, [25:2] sample, [27:26] status
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	lcasr_pkg::cfg_t    cfg_q;
	lcasr_pkg::result_t res;

	logic        in_valid_s1;
	logic        kind_s1;
	logic        dout_s1;
	logic        out_valid_q;
	logic [31:0] out_data_q;
	logic        out_free;
	logic        step_en;

	// Configuration writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_select       <= lcasr_pkg::GAIN_RST;
			cfg_q.timeout_ticks     <= lcasr_pkg::TIMEOUT_RST;
			cfg_q.half_period_ticks <= lcasr_pkg::HALF_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				lcasr_pkg::CFG_GAIN:    cfg_q.gain_select       <= cfg_data[1:0];
				lcasr_pkg::CFG_TIMEOUT: cfg_q.timeout_ticks     <= cfg_data;
				lcasr_pkg::CFG_HALF:    cfg_q.half_period_ticks <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// Pipeline control
	assign out_free      = !out_valid_q || m_axis_tready;
	assign step_en       = in_valid_s1 && out_free;
	assign s_axis_tready = !in_valid_s1 || out_free;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			kind_s1 <= s_axis_tuser;
			dout_s1 <= s_axis_tdata[0];
		end
	end

	lcasr_core #(
		.POWERDOWN_TICKS(POWERDOWN_TICKS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_en    (step_en),
		.kind       (kind_s1),
		.dout_level (dout_s1),
		.cfg        (cfg_q),
		.res        (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= in_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			out_data_q <= {4'd0, res.status, res.sample, res.sample_valid, res.sck};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

>>> src/lcasr_checker.sv
// Port-level checks for the load-cell converter serial reader, bound to the top level.
// Depends on lcasr_pkg and load_cell_adc_serial_reader.
module lcasr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata
);

	// A result is reported at the end of a low clock phase
	a_valid_sck_low: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[1]) |-> !m_axis_tdata[0])
		else $error("sample reported with sck high");

	// Sample field is zero on ticks without a result
	a_sample_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tdata[1]) |-> (m_axis_tdata[25:2] == 24'd0))
		else $error("nonzero sample without sample_valid");

	// Power-down phase holds the clock high
	a_start_sck_high: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[27:26] == lcasr_pkg::STATUS_START) |-> m_axis_tdata[0])
		else $error("starting status with sck low");

	// A result on a rail raises the saturation warning
	a_rail_warn: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[1] &&
		 (m_axis_tdata[25:2] == lcasr_pkg::RAIL_POS || m_axis_tdata[25:2] == lcasr_pkg::RAIL_NEG))
		|-> (m_axis_tdata[27:26] == lcasr_pkg::STATUS_SAT))
		else $error("rail sample without saturation warning");

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("stalled result changed");

endmodule

bind load_cell_adc_serial_reader lcasr_checker u_lcasr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

>>> tb/load_cell_adc_serial_reader_tb.sv
// Self-checking testbench for load_cell_adc_serial_reader: tick and restart streams in,
// one predicted result per tick out, several register settings and back-pressure phases.
// Depends on lcasr_pkg and the load_cell_adc_serial_reader RTL.
module load_cell_adc_serial_reader_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PD_TICKS    = 70;
	localparam int HOLD_CYCLES = 60;
	localparam int STALL_LIMIT = 2000;

	// Register index with no register behind it, and the gain code with no channel
	localparam logic [1:0] CFG_SPARE   = 2'd3;
	localparam logic [1:0] GAIN_UNUSED = 2'd3;

	// Idling schemes
	localparam int IDLE_NONE     = 0;
	localparam int IDLE_SENDER   = 1;
	localparam int IDLE_RECEIVER = 2;
	localparam int IDLE_BOTH     = 3;

	typedef enum logic [2:0] {
		RD_PDOWN, RD_WAIT, RD_BIT_HI, RD_BIT_LO, RD_EXT_HI, RD_EXT_LO, RD_FAULT
	} rd_mode_t;

	typedef struct packed {
		logic kind;
		logic dout;
	} tick_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = '0;  // [0] dout_level, [7:1] zero
	logic        s_axis_tuser  = 1'b0; // [0] kind
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;        // [0] sck, [1] sample_valid, [25:2] sample, [27:26] status
	logic        cfg_valid     = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index     = '0;
	logic [23:0] cfg_data      = '0;

	// Register copies used by the predictor
	logic [1:0]  cfg_gain    = lcasr_pkg::GAIN_RST;
	logic [23:0] cfg_timeout = lcasr_pkg::TIMEOUT_RST;
	logic [5:0]  cfg_half    = lcasr_pkg::HALF_RST;

	// Predicted reader state
	rd_mode_t    rd_mode     = RD_PDOWN;
	logic [23:0] shreg       = '0;
	int          bits_in     = 0;
	int          phase_ticks = 0;
	int          pulses_left = 0;
	logic [23:0] idle_ticks  = '0;
	int          pd_ticks    = 0;
	logic        rail_hit    = 1'b0;

	tick_t              tick_plan[$];
	lcasr_pkg::result_t result_due[$];
	int      pushed       = 0;
	int      idle_mode    = IDLE_NONE;
	int      hold_reqs    = 0;
	int      holds_done   = 0;
	int      hold_left    = 0;
	int      stall_cycles = 0;
	int      errors       = 0;
	logic    s_taken      = 1'b0;

	load_cell_adc_serial_reader #(
		.POWERDOWN_TICKS(PD_TICKS)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	// Extra pulses after the data bits; the spare code behaves as gain 128
	function automatic int gain_pulses(input logic [1:0] g);
		case (g)
			lcasr_pkg::GAIN_64: return 3;
			lcasr_pkg::GAIN_32: return 2;
			default:            return 1;
		endcase
	endfunction

	// Ends the current clock phase when its last tick comes; zero half period acts as one
	function automatic logic half_done();
		int hp;
		hp = (cfg_half == 0) ? 1 : int'(cfg_half);
		if (phase_ticks + 1 >= hp) begin
			phase_ticks = 0;
			return 1'b1;
		end
		phase_ticks++;
		return 1'b0;
	endfunction

	// Advances the reader by one tick or restart and gives the result of that call
	task automatic predict_tick(input logic kind, input logic dout,
			output lcasr_pkg::result_t r);
		r = '0;
		if (kind == lcasr_pkg::KIND_RESTART) begin
			rd_mode     = RD_PDOWN;
			shreg       = '0;
			bits_in     = 0;
			phase_ticks = 0;
			pulses_left = 0;
			idle_ticks  = '0;
			pd_ticks    = 0;
			rail_hit    = 1'b0;
			r.sck       = 1'b1;
			r.status    = lcasr_pkg::STATUS_START;
		end else begin
			if (rd_mode != RD_PDOWN && rd_mode != RD_FAULT && idle_ticks != lcasr_pkg::COUNT_MAX)
				idle_ticks++;
			case (rd_mode)
				RD_PDOWN: begin
					r.sck = 1'b1;
					pd_ticks++;
					if (pd_ticks >= PD_TICKS) begin
						pd_ticks   = 0;
						idle_ticks = '0;
						rd_mode    = RD_WAIT;
					end
				end
				RD_WAIT: begin
					if (dout == 1'b0) begin
						shreg       = '0;
						bits_in     = 0;
						phase_ticks = 0;
						rd_mode     = RD_BIT_HI;
					end else if (idle_ticks > cfg_timeout) begin
						rd_mode = RD_FAULT;
					end
				end
				RD_BIT_HI: begin
					r.sck = 1'b1;
					if (half_done()) begin
						shreg   = {shreg[22:0], dout};
						bits_in++;
						rd_mode = RD_BIT_LO;
					end
				end
				RD_BIT_LO: begin
					if (half_done()) begin
						if (bits_in >= lcasr_pkg::DATA_BITS) begin
							pulses_left = gain_pulses(cfg_gain);
							rd_mode     = RD_EXT_HI;
						end else begin
							rd_mode = RD_BIT_HI;
						end
					end
				end
				RD_EXT_HI: begin
					r.sck = 1'b1;
					if (half_done())
						rd_mode = RD_EXT_LO;
				end
				RD_EXT_LO: begin
					if (half_done()) begin
						pulses_left--;
						if (pulses_left == 0) begin
							rail_hit       = (shreg == lcasr_pkg::RAIL_POS ||
								shreg == lcasr_pkg::RAIL_NEG);
							r.sample_valid = 1'b1;
							r.sample       = shreg;
							idle_ticks     = '0;
							bits_in        = 0;
							rd_mode        = RD_WAIT;
						end else begin
							rd_mode = RD_EXT_HI;
						end
					end
				end
				default: rd_mode = RD_FAULT;
			endcase
			if (rd_mode == RD_PDOWN)
				r.status = lcasr_pkg::STATUS_START;
			else if (rd_mode == RD_FAULT)
				r.status = lcasr_pkg::STATUS_FAULT;
			else
				r.status = rail_hit ? lcasr_pkg::STATUS_SAT : lcasr_pkg::STATUS_RUN;
		end
	endtask

	function automatic bit sender_gap();
		case (idle_mode)
			IDLE_SENDER: return $urandom_range(99) < 73;
			IDLE_BOTH:   return $urandom_range(99) < 38;
			default:     return 1'b0;
		endcase
	endfunction

	function automatic bit receiver_stall();
		case (idle_mode)
			IDLE_RECEIVER: return $urandom_range(99) < 73;
			IDLE_BOTH:     return $urandom_range(99) < 38;
			default:       return 1'b0;
		endcase
	endfunction

	// Input driver: a new tick goes out once the last one was taken
	always @(negedge clk) begin
		tick_t t;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || s_taken) begin
			if (tick_plan.size() != 0 && !sender_gap()) begin
				t = tick_plan.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= {7'b0, t.dout};
				s_axis_tuser  <= t.kind;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Result side ready, with random stalls and an occasional long hold-off
	always @(negedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			m_axis_tready <= 1'b0;
			hold_left     <= hold_left - 1;
		end else if (hold_reqs != holds_done) begin
			m_axis_tready <= 1'b0;
			hold_left     <= HOLD_CYCLES;
			holds_done    <= holds_done + 1;
		end else begin
			m_axis_tready <= !receiver_stall();
		end
	end

	// Monitor: check each result transaction, predict each accepted tick
	always @(posedge clk) begin
		lcasr_pkg::result_t want;
		lcasr_pkg::result_t got;
		if (m_axis_tvalid && m_axis_tready) begin
			got.sck          = m_axis_tdata[0];
			got.sample_valid = m_axis_tdata[1];
			got.sample       = m_axis_tdata[25:2];
			got.status       = m_axis_tdata[27:26];
			if (result_due.size() == 0) begin
				$error("result transaction with nothing expected: tdata %h", m_axis_tdata);
				errors++;
			end else begin
				want = result_due.pop_front();
				if (got.sck !== want.sck) begin
					$error("sck: expected %0d, got %0d", want.sck, got.sck);
					errors++;
				end
				if (got.sample_valid !== want.sample_valid) begin
					$error("sample_valid: expected %0d, got %0d",
						want.sample_valid, got.sample_valid);
					errors++;
				end
				if (got.sample !== want.sample) begin
					$error("sample: expected %0d, got %0d", want.sample, got.sample);
					errors++;
				end
				if (got.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, got.status);
					errors++;
				end
			end
		end
		if (s_axis_tvalid && s_axis_tready) begin
			predict_tick(s_axis_tuser, s_axis_tdata[0], want);
			result_due.push_back(want);
		end
		s_taken <= s_axis_tvalid && s_axis_tready;
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	// Watchdog on cycles without any transaction
	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("load_cell_adc_serial_reader: mismatch");
		$finish;
	end

	task automatic push_tick(input logic kind, input logic dout);
		tick_plan.push_back('{kind: kind, dout: dout});
		pushed++;
	endtask

	// Restart followed by the whole power-down stretch
	task automatic push_restart();
		push_tick(lcasr_pkg::KIND_RESTART, 1'($urandom_range(1)));
		repeat (PD_TICKS) push_tick(lcasr_pkg::KIND_TICK, 1'($urandom_range(1)));
	endtask

	// Conversion seen from the data line: wait with the line high, the ready tick,
	// bits first_bit..last_bit-1 held over their high phase, then the extra pulses
	task automatic push_frame(input logic [23:0] v, input int wait_len, input int first_bit,
			input int last_bit, input bit with_extra);
		int hp;
		hp = (cfg_half == 0) ? 1 : int'(cfg_half);
		if (first_bit == 0) begin
			repeat (wait_len) push_tick(lcasr_pkg::KIND_TICK, 1'b1);
			push_tick(lcasr_pkg::KIND_TICK, 1'b0);
		end
		for (int b = first_bit; b < last_bit; b++) begin
			repeat (hp) push_tick(lcasr_pkg::KIND_TICK, v[23-b]);
			repeat (hp) push_tick(lcasr_pkg::KIND_TICK, 1'($urandom_range(1)));
		end
		if (with_extra)
			repeat (2 * hp * gain_pulses(cfg_gain))
				push_tick(lcasr_pkg::KIND_TICK, 1'($urandom_range(1)));
	endtask

	function automatic logic [23:0] pick_sample();
		case ($urandom_range(11))
			0:       return lcasr_pkg::RAIL_POS;
			1:       return lcasr_pkg::RAIL_NEG;
			2:       return lcasr_pkg::RAIL_POS - 24'd1;
			3:       return lcasr_pkg::RAIL_NEG + 24'd1;
			4:       return '0;
			5:       return lcasr_pkg::COUNT_MAX;
			default: return 24'($urandom);
		endcase
	endfunction

	// Mostly whole conversions; some cut short, noise or a dead data line, each
	// followed by a restart so the plan stays aligned with the reader
	task automatic random_frames(input int budget);
		int start;
		int r;
		int wait_len;
		start = pushed;
		while (pushed - start < budget) begin
			r = $urandom_range(99);
			if (r < 6) begin
				push_frame(pick_sample(), 0, 0, $urandom_range(23), 1'b0);
				push_restart();
			end else if (r < 10) begin
				repeat ($urandom_range(5, 30))
					push_tick(lcasr_pkg::KIND_TICK, 1'($urandom_range(1)));
				push_restart();
			end else if (r < 16 && cfg_timeout <= 64) begin
				repeat (cfg_timeout + $urandom_range(1, 8)) push_tick(lcasr_pkg::KIND_TICK, 1'b1);
				repeat ($urandom_range(1, 6))
					push_tick(lcasr_pkg::KIND_TICK, 1'($urandom_range(1)));
				push_restart();
			end else begin
				wait_len = (cfg_timeout <= 64) ? $urandom_range(0, cfg_timeout) :
					$urandom_range(0, 6);
				push_frame(pick_sample(), wait_len, 0, lcasr_pkg::DATA_BITS, 1'b1);
			end
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			lcasr_pkg::CFG_GAIN:    cfg_gain    = val[1:0];
			lcasr_pkg::CFG_TIMEOUT: cfg_timeout = val;
			lcasr_pkg::CFG_HALF:    cfg_half    = val[5:0];
			default:                ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Wait until every planned tick went out and every result came back
	task automatic drain();
		while (tick_plan.size() != 0 || s_axis_tvalid || result_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Stimulus phases; all but the first, last and split-read tail start with the reader waiting
	initial begin
		logic [23:0] split_val;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: restart inside power-down, both rails, zero and all ones
		idle_mode = IDLE_NONE;
		repeat (10) push_tick(lcasr_pkg::KIND_TICK, 1'($urandom_range(1)));
		push_restart();
		push_frame(lcasr_pkg::RAIL_POS, 3, 0, lcasr_pkg::DATA_BITS, 1'b1);
		push_frame(lcasr_pkg::RAIL_NEG, 0, 0, lcasr_pkg::DATA_BITS, 1'b1);
		push_frame('0, 1, 0, lcasr_pkg::DATA_BITS, 1'b1);
		push_frame(lcasr_pkg::COUNT_MAX, 2, 0, lcasr_pkg::DATA_BITS, 1'b1);
		drain();

		// Gain 64, short timeout, sender gaps
		write_reg(lcasr_pkg::CFG_GAIN, 24'(lcasr_pkg::GAIN_64));
		write_reg(lcasr_pkg::CFG_TIMEOUT, 24'd30);
		write_reg(lcasr_pkg::CFG_HALF, 24'd2);
		idle_mode = IDLE_SENDER;
		random_frames(100);
		drain();

		// Gain 32, timeout of one tick, receiver stalls plus a long hold-off
		write_reg(lcasr_pkg::CFG_GAIN, 24'(lcasr_pkg::GAIN_32));
		write_reg(lcasr_pkg::CFG_TIMEOUT, 24'd1);
		write_reg(lcasr_pkg::CFG_HALF, 24'd1);
		idle_mode = IDLE_RECEIVER;
		random_frames(100);
		hold_reqs++;
		drain();

		// Spare gain code, zero timeout, zero half period
		write_reg(lcasr_pkg::CFG_GAIN, 24'(GAIN_UNUSED));
		write_reg(lcasr_pkg::CFG_TIMEOUT, 24'd0);
		write_reg(lcasr_pkg::CFG_HALF, 24'd0);
		idle_mode = IDLE_BOTH;
		random_frames(100);
		drain();

		// Gain changed in the middle of a read; timeout that never fires
		write_reg(lcasr_pkg::CFG_GAIN, 24'(lcasr_pkg::GAIN_128));
		write_reg(lcasr_pkg::CFG_TIMEOUT, lcasr_pkg::COUNT_MAX);
		write_reg(lcasr_pkg::CFG_HALF, 24'd3);
		idle_mode = IDLE_NONE;
		split_val = pick_sample();
		push_frame(split_val, 2, 0, 20, 1'b0);
		drain();
		write_reg(lcasr_pkg::CFG_GAIN, 24'(lcasr_pkg::GAIN_64));
		push_frame(split_val, 0, 20, lcasr_pkg::DATA_BITS, 1'b1);
		drain();

		// Longest half period in this bench (50)
		write_reg(lcasr_pkg::CFG_HALF, 24'd50);
		write_reg(lcasr_pkg::CFG_TIMEOUT, 24'd5);
		write_reg(lcasr_pkg::CFG_GAIN, 24'(lcasr_pkg::GAIN_32));
		idle_mode = IDLE_SENDER;
		push_tick(lcasr_pkg::KIND_TICK, 1'b0);
		repeat (100) push_tick(lcasr_pkg::KIND_TICK, 1'($urandom_range(1)));
		drain();

		// Unmapped register index, then reset values again
		write_reg(CFG_SPARE, 24'($urandom));
		write_reg(lcasr_pkg::CFG_GAIN, 24'(lcasr_pkg::GAIN_RST));
		write_reg(lcasr_pkg::CFG_TIMEOUT, lcasr_pkg::TIMEOUT_RST);
		write_reg(lcasr_pkg::CFG_HALF, 24'(lcasr_pkg::HALF_RST));
		idle_mode = IDLE_BOTH;
		push_restart();
		random_frames(80);
		drain();

		if (errors == 0)
			$display("load_cell_adc_serial_reader: match");
		else
			$display("load_cell_adc_serial_reader: mismatch");
		$finish;
	end

endmodule

>>> load_cell_adc_serial_reader.f
src/lcasr_pkg.sv
src/lcasr_core.sv
src/load_cell_adc_serial_reader.sv
src/lcasr_checker.sv
tb/load_cell_adc_serial_reader_tb.sv
